// ----- src/tcci_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcci_pkg
// Shared types and constants of the temperature compensated calibration block.
// ----------------------------------------------------------------------------
package tcci_pkg;

    localparam int MAX_POINTS_DEF = 8;
    localparam int MAX_ROWS_DEF   = 3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_NO_ROW   = 2'd2;

    localparam logic [1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROW0_PTS  = 2'd1;
    localparam logic [1:0] CFG_ROW1_PTS  = 2'd2;
    localparam logic [1:0] CFG_ROW2_PTS  = 2'd3;

    localparam logic CMD_CONVERT = 1'b0;
    localparam logic CMD_WRITE   = 1'b1;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_MEM_READ  = 4'd1,  // read table entry at (row, col)
        OP_LOAD_A    = 4'd2,  // latch read data as point a
        OP_LOAD_B    = 4'd3,  // latch read data as point b
        OP_LERP_V    = 4'd4,  // start value division
        OP_LERP_T    = 4'd5,  // start temperature division
        OP_PAIR_SAVE = 4'd6,  // store row pair
        OP_PAIR_RD   = 4'd7,  // load pairs i, i+1 as a/b of second stage
        OP_LERP_F    = 4'd8,  // start final division
        OP_FIN_DONE  = 4'd9,  // latch final value
        OP_ONE_ROW   = 4'd10  // single row result
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] row;
        logic [4:0] col;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic key_le;   // sample sig <= b.sig
        logic key_ge;   // sample sig >= a.sig
        logic rising;   // a.sig < b.sig
        logic pkey_le;  // temp <= pair[i+1].tmp
        logic pkey_ge;  // temp >= pair[i].tmp
        logic prising;  // pair[i].tmp < pair[i+1].tmp
    } dp_stat_t;

endpackage

// ----- src/tcci_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcci_div
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module tcci_div
    import tcci_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [31:0] den,
    output logic               busy,
    output logic signed [63:0] quo
);

    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [33:0] trial;

    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        trial    = {r_reg, q_reg[63]} - {2'b00, d_reg};
        if (start)
        begin
            q_next   = num[63] ? 64'(-num) : num;
            d_next   = den[31] ? 32'(-den) : den;
            r_next   = '0;
            neg_next = num[63] ^ den[31];
            cnt_next = 7'd64;
        end
        else if (cnt_reg != 7'd0)
        begin
            if (!trial[33])
                r_next = trial[32:0];
            else
                r_next = {r_reg[31:0], q_reg[63]};
            q_next   = {q_reg[62:0], ~trial[33]};
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign busy = (cnt_reg != 7'd0);
    assign quo  = neg_reg ? 64'(-q_reg) : q_reg;

endmodule

// ----- src/tcci_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcci_datapath
// Calibration table, point registers, multiplier and divider of the block.
// ----------------------------------------------------------------------------
module tcci_datapath
    import tcci_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic               wr_en,
    input  logic [$clog2(MAX_ROWS*MAX_POINTS)-1:0] wr_addr,
    input  logic [63:0]        wr_data,
    input  logic signed [15:0] sig_in,
    input  logic signed [15:0] tmp_in,
    output dp_stat_t           stat,
    output logic signed [31:0] value
);

    localparam int DEPTH = MAX_ROWS * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_POINTS);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [63:0] mem [DEPTH];
    logic [63:0] rd_reg;

    logic signed [31:0] av_reg, bv_reg;
    logic signed [15:0] as_reg, bs_reg, at_reg, bt_reg;
    logic signed [31:0] pv_reg [MAX_ROWS];
    logic signed [15:0] pt_reg [MAX_ROWS];
    logic signed [31:0] rv_reg;
    logic signed [31:0] fin_reg;
    logic signed [15:0] xs_reg;

    logic               div_start;
    logic signed [63:0] div_num;
    logic signed [31:0] div_den;
    logic signed [63:0] quo;
    logic               div_busy;
    logic signed [32:0] dy;
    logic signed [16:0] dx;
    logic signed [16:0] dxs;
    logic signed [49:0] prod;
    logic signed [64:0] sum_v;
    logic signed [64:0] sum_t;
    logic               flat;

    logic [AW-1:0] rd_addr;
    assign rd_addr = AW'(cmd.row * MAX_POINTS + {27'd0, cmd.col[PW-1:0]});

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.op == OP_MEM_READ)
            rd_reg <= mem[rd_addr];
    end

    tcci_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (quo)
    );

    // numerator dy * (x - x0), denominator x1 - x0
    always_comb
    begin
        dy        = '0;
        dxs       = 17'(xs_reg) - 17'(as_reg);
        dx        = 17'(bs_reg) - 17'(as_reg);
        div_start = 1'b0;
        case (cmd.op)
            OP_LERP_V:
            begin
                dy        = 33'(bv_reg) - 33'(av_reg);
                div_start = 1'b1;
            end
            OP_LERP_T:
            begin
                dy        = 33'(bt_reg) - 33'(at_reg);
                div_start = 1'b1;
            end
            OP_LERP_F:
            begin
                dy        = 33'(bv_reg) - 33'(av_reg);
                div_start = 1'b1;
            end
            default: ;
        endcase
        prod    = 50'(dy) * 50'(dxs);
        div_num = 64'(prod);
        div_den = 32'(dx);
    end

    assign flat  = (bs_reg == as_reg);
    assign sum_v = flat ? 65'(av_reg) : 65'(av_reg) + 65'(quo);
    assign sum_t = flat ? 65'(at_reg) : 65'(at_reg) + 65'(quo);

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        if (v > 65'sd2147483647)
            return 32'h7FFFFFFF;
        else if (v < -65'sd2147483648)
            return 32'h80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [64:0] v);
        if (v > 65'sd32767)
            return 16'h7FFF;
        else if (v < -65'sd32768)
            return 16'h8000;
        else
            return v[15:0];
    endfunction

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_MEM_READ:
                xs_reg <= sig_in;
            OP_LOAD_A:
            begin
                av_reg <= rd_reg[31:0];
                as_reg <= rd_reg[47:32];
                at_reg <= rd_reg[63:48];
            end
            OP_LOAD_B:
            begin
                bv_reg <= rd_reg[31:0];
                bs_reg <= rd_reg[47:32];
                bt_reg <= rd_reg[63:48];
            end
            OP_LERP_T:
                rv_reg <= sat32(sum_v);
            OP_PAIR_SAVE:
            begin
                pv_reg[cmd.row[RW-1:0]] <= rv_reg;
                pt_reg[cmd.row[RW-1:0]] <= sat16(sum_t);
            end
            OP_PAIR_RD:
            begin
                av_reg <= pv_reg[cmd.col[RW-1:0]];
                as_reg <= pt_reg[cmd.col[RW-1:0]];
                bv_reg <= pv_reg[RW'(cmd.col[RW-1:0] + 1'b1)];
                bs_reg <= pt_reg[RW'(cmd.col[RW-1:0] + 1'b1)];
                xs_reg <= tmp_in;
            end
            OP_FIN_DONE:
                fin_reg <= sat32(sum_v);
            OP_ONE_ROW:
                fin_reg <= pv_reg[0];
            default: ;
        endcase
    end

    assign stat.div_busy = div_busy;
    assign stat.rising   = as_reg < bs_reg;
    assign stat.key_le   = xs_reg <= bs_reg;
    assign stat.key_ge   = xs_reg >= as_reg;
    assign stat.prising  = as_reg < bs_reg;
    assign stat.pkey_le  = xs_reg <= bs_reg;
    assign stat.pkey_ge  = xs_reg >= as_reg;
    assign value         = fin_reg;

endmodule

// ----- src/tcci_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcci_ctrl
// Sequencer: segment search and two lerps per row; final lerp if >1 row used.
// ----------------------------------------------------------------------------
module tcci_ctrl
    import tcci_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [3:0]  nrows,
    input  logic [5:0]  npts [MAX_ROWS],
    input  dp_stat_t    stat,
    output dp_cmd_t     cmd,
    output logic        busy,
    output logic        done,
    output logic [3:0]  used
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_ROW   = 11'b00000000010,
        S_RDA   = 11'b00000000100,
        S_LDA   = 11'b00000001000,
        S_RDB   = 11'b00000010000,
        S_CHK   = 11'b00000100000,
        S_LV    = 11'b00001000000,
        S_LT    = 11'b00010000000,
        S_SAVE  = 11'b00100000000,
        S_PAIR  = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] r_reg, r_next;
    logic [5:0] i_reg, i_next;
    logic [3:0] j_reg, j_next;
    logic [1:0] ph_reg, ph_next;
    logic       done_reg, done_next;
    logic [5:0] n;
    logic       last_seg;

    assign n        = (r_reg < 4'(MAX_ROWS)) ? npts[r_reg[RW-1:0]] : 6'd0;
    assign last_seg = (state_reg == S_PAIR) ? (6'(i_reg) + 6'd2 >= 6'(j_reg))
                                            : (i_reg + 6'd2 >= n);

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ph_next    = ph_reg;
        done_next  = 1'b0;
        cmd        = '{op: OP_NONE, row: 3'(r_reg), col: 5'(i_reg)};
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    r_next     = '0;
                    j_next     = '0;
                    state_next = S_ROW;
                end
            S_ROW:
                if (r_reg >= nrows)
                begin
                    i_next     = '0;
                    ph_next    = '0;
                    state_next = S_PAIR;
                end
                else if (n < 6'd2)
                    r_next = r_reg + 4'd1;
                else
                begin
                    i_next     = '0;
                    state_next = S_RDA;
                end
            S_RDA:
            begin
                cmd.op     = OP_MEM_READ;
                state_next = S_LDA;
            end
            S_LDA:
            begin
                cmd.op     = OP_LOAD_A;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.op     = OP_MEM_READ;
                cmd.col    = 5'(i_reg + 6'd1);
                state_next = S_CHK;
                ph_next    = '0;
            end
            S_CHK:
                if (ph_reg == 2'd0)
                begin
                    cmd.op  = OP_LOAD_B;
                    ph_next = 2'd1;
                end
                else if ((stat.rising ? stat.key_le : stat.key_ge) || last_seg)
                    state_next = S_LV;
                else
                begin
                    i_next     = i_reg + 6'd1;
                    state_next = S_RDA;
                end
            S_LV:
            begin
                cmd.op     = OP_LERP_V;
                ph_next    = 2'd0;
                state_next = S_LT;
            end
            S_LT:
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else if (!stat.div_busy)
                begin
                    cmd.op     = OP_LERP_T;
                    ph_next    = 2'd0;
                    state_next = S_SAVE;
                end
            S_SAVE:
                if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else if (!stat.div_busy)
                begin
                    cmd.op     = OP_PAIR_SAVE;
                    cmd.row    = 3'(j_reg);
                    j_next     = j_reg + 4'd1;
                    r_next     = r_reg + 4'd1;
                    state_next = S_ROW;
                end
            S_PAIR:
                if (j_reg < 4'd2)
                begin
                    if (j_reg == 4'd1)
                        cmd.op = OP_ONE_ROW;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (ph_reg == 2'd0)
                begin
                    cmd.op  = OP_PAIR_RD;
                    ph_next = 2'd1;
                end
                else if ((stat.prising ? stat.pkey_le : stat.pkey_ge) || last_seg)
                begin
                    cmd.op     = OP_LERP_F;
                    ph_next    = 2'd0;
                    state_next = S_FIN;
                end
                else
                begin
                    i_next  = i_reg + 6'd1;
                    ph_next = 2'd0;
                end
            S_FIN:
                if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else if (!stat.div_busy)
                begin
                    cmd.op     = OP_FIN_DONE;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            r_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            ph_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ph_reg    <= ph_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign used = j_reg;

endmodule

// ----- src/temp_compensated_calib_interp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_compensated_calib_interp
// Temperature compensated two stage piecewise linear calibration.
// ----------------------------------------------------------------------------
// A write item's result is presented the cycle after the item is accepted. A
// convert item walks each row's segments one at a time (two table reads each);
// a row with two or more points then runs two 64-bit serial divisions, and a
// row with fewer points is skipped. When two or more rows gave a result, the
// temperature stage checks pairs of row results one at a time and runs one
// more division. One item is in work at a time; the next item is accepted in
// the cycle the waiting result is taken.
module temp_compensated_calib_interp
    import tcci_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [15:0] sig_adc,
    input  logic signed [15:0] temp_adc,
    input  logic signed [31:0] point_value,
    input  logic [1:0]         row_sel,
    input  logic [2:0]         col_sel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result_value,
    output logic [1:0]         status,
    output logic [1:0]         rows_used,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AW = $clog2(MAX_ROWS * MAX_POINTS);

    logic [1:0]  row_count_reg;
    logic [3:0]  pts_reg [3];
    logic [3:0]  nrows;
    logic [5:0]  npts [MAX_ROWS];
    logic        ctrl_start, ctrl_busy, ctrl_done;
    logic [3:0]  used;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic signed [31:0] value;
    logic signed [15:0] sig_reg, tmp_reg;
    logic        wr_en, wr_ok, accept;
    logic [AW-1:0] wr_addr;
    logic        pend_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= 2'd1;
            pts_reg[0]    <= 4'd8;
            pts_reg[1]    <= 4'd8;
            pts_reg[2]    <= 4'd8;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROW_COUNT: row_count_reg <= cfg_data[1:0];
                CFG_ROW0_PTS:  pts_reg[0]    <= cfg_data[3:0];
                CFG_ROW1_PTS:  pts_reg[1]    <= cfg_data[3:0];
                CFG_ROW2_PTS:  pts_reg[2]    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign nrows = ({2'b00, row_count_reg} > 4'(MAX_ROWS)) ? 4'(MAX_ROWS)
                                                          : {2'b00, row_count_reg};

    always_comb
    begin
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            if (r > 2)
                npts[r] = '0;
            else if ({2'b00, pts_reg[r]} > 6'(MAX_POINTS))
                npts[r] = 6'(MAX_POINTS);
            else
                npts[r] = {2'b00, pts_reg[r]};
        end
    end

    assign in_ready   = !ctrl_busy && !pend_reg && (!out_valid || out_ready);
    assign accept     = in_valid && in_ready;
    assign wr_ok      = ({2'b00, row_sel} < nrows) && (32'(col_sel) < MAX_POINTS);
    assign wr_en      = accept && (command == CMD_WRITE) && wr_ok;
    assign wr_addr    = AW'(row_sel * MAX_POINTS + 32'(col_sel));
    assign ctrl_start = accept && (command == CMD_CONVERT);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sig_reg <= sig_adc;
            tmp_reg <= temp_adc;
        end
    end

    tcci_ctrl #(.MAX_POINTS(MAX_POINTS), .MAX_ROWS(MAX_ROWS)) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl_start),
        .nrows (nrows),
        .npts  (npts),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (ctrl_busy),
        .done  (ctrl_done),
        .used  (used)
    );

    tcci_datapath #(.MAX_POINTS(MAX_POINTS), .MAX_ROWS(MAX_ROWS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({temp_adc, sig_adc, point_value}),
        .sig_in  (sig_reg),
        .tmp_in  (tmp_reg),
        .stat    (stat),
        .value   (value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if ((accept && command == CMD_WRITE) || ctrl_done)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
            if (ctrl_start)
                pend_reg <= 1'b1;
            else if (ctrl_done)
                pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_WRITE)
        begin
            result_value <= '0;
            status       <= wr_ok ? ST_OK : ST_REJECTED;
            rows_used    <= '0;
        end
        else if (ctrl_done)
        begin
            result_value <= (used == 4'd0) ? 32'sd0 : value;
            status       <= (used == 4'd0) ? ST_NO_ROW : ST_OK;
            rows_used    <= used[1:0];
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_busy |-> !in_ready)
        else $error("item accepted during conversion");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_done |=> out_valid)
        else $error("conversion result lost");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_start |-> !pend_reg)
        else $error("conversion started twice");

endmodule

// ----- dv/temp_compensated_calib_interp_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_compensated_calib_interp_tb
// Self-checking bench for the two-stage calibration interpolator.
// ----------------------------------------------------------------------------
// The table is filled first. A directed table then covers rejected writes,
// flat segments, field extremes, one valid row and no valid row. Random writes
// and conversions follow under a series of register settings. Results are
// checked against an in-bench calibration math predictor or a typed result.
// ----------------------------------------------------------------------------
module temp_compensated_calib_interp_tb;
    import tcci_pkg::*;

    localparam int NPTS  = MAX_POINTS_DEF;
    localparam int NROWS = MAX_ROWS_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 700;

    typedef enum logic {ROW_ITEM, ROW_CFG} step_kind_t;

    typedef struct {
        logic               cmd;
        logic signed [15:0] sig;
        logic signed [15:0] tmp;
        logic signed [31:0] val;
        logic [1:0]         row;
        logic [2:0]         col;
    } sample_t;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         stat;
        logic [1:0]         used;
    } calib_res_t;

    typedef struct {
        step_kind_t kind;
        logic [1:0] idx;
        logic [31:0] data;
        sample_t    it;
        bit         typed;
        calib_res_t res;
    } step_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready;
    logic command;
    logic signed [15:0] sig_adc, temp_adc;
    logic signed [31:0] point_value;
    logic [1:0] row_sel;
    logic [2:0] col_sel;
    logic out_valid, out_ready;
    logic signed [31:0] result_value;
    logic [1:0] status, rows_used;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    temp_compensated_calib_interp dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .sig_adc(sig_adc), .temp_adc(temp_adc),
        .point_value(point_value), .row_sel(row_sel), .col_sel(col_sel),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .status(status), .rows_used(rows_used),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of table and registers
    longint     tbl_val [NROWS*NPTS];
    longint     tbl_sig [NROWS*NPTS];
    longint     tbl_tmp [NROWS*NPTS];
    logic [1:0] m_rows;
    logic [3:0] m_pts [3];

    calib_res_t pending_results[$];
    int errors = 0;
    int n_results = 0, n_convert = 0, n_write = 0, n_reject = 0, n_norow = 0;
    int n_multi = 0, n_cfg = 0;
    bit gap_free = 0;
    step_t steps[$];

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        int cyc;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cyc);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int find_segment(longint k[8], int n, longint x);
        int i;
        for (i = 0; i + 1 < n; i++)
        begin
            if (k[i] < k[i+1])
            begin
                if (x <= k[i+1]) break;
            end
            else if (x >= k[i]) break;
        end
        if (i >= n - 1) i = n - 2;
        return i;
    endfunction

    function automatic longint interp(longint y0, longint y1, longint x0, longint x1,
                                      longint x);
        longint dx;
        dx = x1 - x0;
        if (dx == 0) return y0;
        return y0 + ((y1 - y0) * (x - x0)) / dx;
    endfunction

    function automatic int row_points(int r);
        int n;
        n = int'(m_pts[r]);
        return n > NPTS ? NPTS : n;
    endfunction

    // applies a write to the table copy or computes a conversion
    function automatic calib_res_t calibrate(sample_t it);
        calib_res_t r;
        longint pv[3];
        longint pt[3];
        longint keys[8];
        int nr, j, n, i, b;
        nr = m_rows > NROWS ? NROWS : int'(m_rows);
        r.value = 0;
        r.stat = ST_OK;
        r.used = 0;
        if (it.cmd == CMD_WRITE)
        begin
            if (it.row >= nr) r.stat = ST_REJECTED;
            else
            begin
                tbl_val[it.row*NPTS + it.col] = longint'(it.val);
                tbl_sig[it.row*NPTS + it.col] = longint'(it.sig);
                tbl_tmp[it.row*NPTS + it.col] = longint'(it.tmp);
            end
            return r;
        end
        j = 0;
        for (int rr = 0; rr < nr; rr++)
        begin
            n = row_points(rr);
            if (n < 2) continue;
            b = rr * NPTS;
            for (int k = 0; k < n; k++) keys[k] = tbl_sig[b + k];
            i = b + find_segment(keys, n, longint'(it.sig));
            pv[j] = clamp(interp(tbl_val[i], tbl_val[i+1], tbl_sig[i], tbl_sig[i+1],
                                 longint'(it.sig)), -64'sd2147483648, 64'sd2147483647);
            pt[j] = clamp(interp(tbl_tmp[i], tbl_tmp[i+1], tbl_sig[i], tbl_sig[i+1],
                                 longint'(it.sig)), -64'sd32768, 64'sd32767);
            j++;
        end
        if (j == 0) r.stat = ST_NO_ROW;
        else if (j == 1) r.value = 32'(pv[0]);
        else
        begin
            for (int k = 0; k < j; k++) keys[k] = pt[k];
            i = find_segment(keys, j, longint'(it.tmp));
            r.value = 32'(clamp(interp(pv[i], pv[i+1], pt[i], pt[i+1], longint'(it.tmp)),
                                -64'sd2147483648, 64'sd2147483647));
        end
        r.used = 2'(j);
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ROW_COUNT: m_rows = data[1:0];
            CFG_ROW0_PTS:  m_pts[0] = data[3:0];
            CFG_ROW1_PTS:  m_pts[1] = data[3:0];
            default:       m_pts[2] = data[3:0];
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // in_valid is left high after acceptance; the next call lowers it on a gap
    task automatic send(sample_t it, bit typed, calib_res_t typed_res);
        calib_res_t r;
        int gap;
        gap = gap_free ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        in_valid    <= 1;
        command     <= it.cmd;
        sig_adc     <= it.sig;
        temp_adc    <= it.tmp;
        point_value <= it.val;
        row_sel     <= it.row;
        col_sel     <= it.col;
        do @(posedge clk); while (!in_ready);
        r = calibrate(it);
        if (it.cmd == CMD_WRITE) n_write++; else n_convert++;
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic finish_items();
        @(negedge clk);
        in_valid <= 0;
    endtask

    function automatic sample_t rand_sample(bit is_write);
        sample_t s;
        s.cmd = is_write ? CMD_WRITE : CMD_CONVERT;
        s.sig = 16'($urandom);
        s.tmp = 16'($urandom);
        s.val = $urandom;
        s.row = 2'($urandom_range(0, 3));
        s.col = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0) s.sig = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if ($urandom_range(0, 9) == 0) s.tmp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        return s;
    endfunction

    function automatic step_t item_step(logic cmd, int sig, int tmp, int val, int row,
                                        int col);
        step_t s;
        s.kind = ROW_ITEM;
        s.it.cmd = cmd;
        s.it.sig = 16'(sig);
        s.it.tmp = 16'(tmp);
        s.it.val = val;
        s.it.row = 2'(row);
        s.it.col = 3'(col);
        s.typed = 0;
        s.res = '{0, ST_OK, 0};
        return s;
    endfunction

    function automatic step_t typed_step(step_t s, logic [1:0] st);
        s.typed = 1;
        s.res = '{0, st, 0};
        return s;
    endfunction

    function automatic step_t cfg_step(logic [1:0] idx, int data);
        step_t s;
        s = item_step(CMD_CONVERT, 0, 0, 0, 0, 0);
        s.kind = ROW_CFG;
        s.idx = idx;
        s.data = data;
        return s;
    endfunction

    // result side
    initial
    begin
        calib_res_t e;
        int stall;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
            if (n_results == 200) stall = 400;
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready <= 0;
                repeat (stall) @(negedge clk);
            end
            else @(negedge clk);
            out_ready <= 1;
            do @(posedge clk); while (!out_valid);
            n_results++;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: value=%0d status=%0d",
                       result_value, status);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status == ST_REJECTED) n_reject++;
                if (status == ST_NO_ROW) n_norow++;
                if (rows_used > 1) n_multi++;
                if (result_value !== e.value)
                begin
                    $error("result_value: expected %0d, got %0d", e.value, result_value);
                    errors++;
                end
                if (status !== e.stat)
                begin
                    $error("status: expected %0d, got %0d", e.stat, status);
                    errors++;
                end
                if (rows_used !== e.used)
                begin
                    $error("rows_used: expected %0d, got %0d", e.used, rows_used);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        sample_t s;
        int mode;
        rst_n = 0;
        in_valid = 0;
        command = CMD_CONVERT;
        sig_adc = 0;
        temp_adc = 0;
        point_value = 0;
        row_sel = 0;
        col_sel = 0;
        cfg_valid = 0;
        cfg_index = CFG_ROW_COUNT;
        cfg_data = 0;
        m_rows = 1;
        m_pts = '{4'd8, 4'd8, 4'd8};
        for (int k = 0; k < NROWS*NPTS; k++)
        begin
            tbl_val[k] = 0;
            tbl_sig[k] = 0;
            tbl_tmp[k] = 0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // fill every entry so no later setting reads an unwritten one
        write_reg(CFG_ROW_COUNT, 3);
        for (int k = 0; k < NROWS*NPTS; k++)
        begin
            s = rand_sample(1);
            s.row = 2'(k / NPTS);
            s.col = 3'(k % NPTS);
            send(s, 0, '{0, ST_OK, 0});
        end

        steps.push_back(typed_step(item_step(CMD_WRITE, 5, 5, 5, 3, 0), ST_REJECTED));
        steps.push_back(typed_step(item_step(CMD_WRITE, 100, 10, 1000, 0, 0), ST_OK));
        steps.push_back(typed_step(item_step(CMD_WRITE, 100, 20, 2000, 0, 1), ST_OK));
        steps.push_back(item_step(CMD_CONVERT, 50, 0, 0, 0, 0));
        steps.push_back(item_step(CMD_CONVERT, 100, 15, 0, 0, 0));
        steps.push_back(item_step(CMD_CONVERT, -32768, 32767, 0, 0, 0));
        steps.push_back(item_step(CMD_CONVERT, 32767, -32768, 0, 0, 0));
        steps.push_back(typed_step(item_step(CMD_WRITE, 32767, -32768, 32'h80000000, 2, 7),
                                   ST_OK));
        steps.push_back(typed_step(item_step(CMD_WRITE, -32768, 32767, 32'h7fffffff, 1, 7),
                                   ST_OK));
        steps.push_back(item_step(CMD_CONVERT, -32768, -32768, 0, 0, 0));
        steps.push_back(item_step(CMD_CONVERT, 32767, 32767, 0, 0, 0));
        steps.push_back(cfg_step(CFG_ROW_COUNT, 1));
        steps.push_back(typed_step(item_step(CMD_WRITE, 1, 1, 1, 1, 0), ST_REJECTED));
        steps.push_back(item_step(CMD_CONVERT, 200, 0, 0, 0, 0));
        steps.push_back(cfg_step(CFG_ROW0_PTS, 1));
        steps.push_back(typed_step(item_step(CMD_CONVERT, 0, 0, 0, 0, 0), ST_NO_ROW));
        steps.push_back(cfg_step(CFG_ROW_COUNT, 0));
        steps.push_back(typed_step(item_step(CMD_CONVERT, 7, 7, 0, 0, 0), ST_NO_ROW));
        steps.push_back(typed_step(item_step(CMD_WRITE, 7, 7, 7, 0, 2), ST_REJECTED));
        steps.push_back(cfg_step(CFG_ROW_COUNT, 3));
        steps.push_back(cfg_step(CFG_ROW0_PTS, 15));
        steps.push_back(cfg_step(CFG_ROW1_PTS, 15));
        steps.push_back(cfg_step(CFG_ROW2_PTS, 2));
        steps.push_back(item_step(CMD_CONVERT, 1234, -500, 0, 0, 0));
        steps.push_back(cfg_step(CFG_ROW1_PTS, 0));
        steps.push_back(item_step(CMD_CONVERT, -1234, 500, 0, 0, 0));
        steps.push_back(cfg_step(CFG_ROW1_PTS, 8));
        steps.push_back(cfg_step(CFG_ROW2_PTS, 8));
        steps.push_back(item_step(CMD_CONVERT, 0, 0, 0, 0, 0));

        foreach (steps[k])
        begin
            if (steps[k].kind == ROW_CFG)
            begin
                finish_items();
                wait_idle();
                write_reg(steps[k].idx, steps[k].data);
            end
            else send(steps[k].it, steps[k].typed, steps[k].res);
        end

        for (int k = 0; k < 1050; k++)
        begin
            if (k % 150 == 0 && k > 0)
            begin
                finish_items();
                wait_idle();
                mode = (k / 150) % 4;
                write_reg(CFG_ROW_COUNT, mode == 1 ? 0 : (mode == 2 ? 2 : 3));
                for (int r = 0; r < 3; r++)
                    write_reg(2'(CFG_ROW0_PTS + r), mode == 3 ?
                              ($urandom_range(0, 1) ? 15 : $urandom_range(0, 8)) :
                              $urandom_range(2, 15));
                if (k == 900) write_reg(CFG_ROW_COUNT, 3);
                gap_free = (mode == 2);
            end
            if (k == 500)
            begin
                finish_items();
                wait_idle();
            end
            send(rand_sample($urandom_range(0, 3) == 0), 0, '{0, ST_OK, 0});
        end
        finish_items();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("covered %0d conversions, %0d writes, %0d register writes",
                 n_convert, n_write, n_cfg);
        $display("results %0d: rejected %0d, no valid row %0d, multi-row %0d",
                 n_results, n_reject, n_norow, n_multi);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tcci_pkg.sv
src/tcci_div.sv
src/tcci_datapath.sv
src/tcci_ctrl.sv
src/temp_compensated_calib_interp.sv
dv/temp_compensated_calib_interp_tb.sv
